/* src/i2f_pkg.sv */
// Package for the int16 to float sample converter.
// Holds widths, float constants and the leading-zero count helper.
// No dependencies.
package i2f_pkg;

	localparam int SampleWidth = 16;
	localparam int FloatWidth  = 32;
	localparam int LzWidth     = 5;

	// exponent bias offsets for the two divisors
	localparam logic [7:0] PosExpBase = 8'd126;
	localparam logic [7:0] NegExpBase = 8'd127;

	// count leading zeros of a 16-bit word; all zeros gives 16
	function automatic logic [LzWidth-1:0] clz16(input logic [SampleWidth-1:0] v);
		logic [LzWidth-1:0] n;
		n = LzWidth'(SampleWidth);
		for (int i = 0; i < SampleWidth; i++) begin
			if (v[i]) begin
				n = LzWidth'(SampleWidth - 1 - i);
			end
		end
		return n;
	endfunction

endpackage

/* src/i2f_convert.sv */
// Combinational sample to binary32 conversion.
// Depends on i2f_pkg.
// Positive samples divide by 32767, negative by 32768.
module i2f_convert (
	input  logic signed [i2f_pkg::SampleWidth-1:0] sample,
	output logic        [i2f_pkg::FloatWidth-1:0]  float_bits
);
	import i2f_pkg::*;

	logic [14:0]          pos_s;
	logic [LzWidth-1:0]   pos_lz;
	logic [44:0]          pos_stream;
	logic [44:0]          pos_shift;
	logic [24:0]          pos_top;
	logic [24:0]          pos_sum;
	logic [7:0]           pos_exp;
	logic [15:0]          neg_m;
	logic [LzWidth-1:0]   neg_lz;
	logic [15:0]          neg_shift;
	logic [7:0]           neg_exp;

	// x/32767 is the 15-bit pattern of x repeated; exact value is never a tie
	always_comb begin
		pos_s      = sample[14:0];
		pos_lz     = clz16({pos_s, 1'b1});
		pos_stream = {pos_s, pos_s, pos_s};
		pos_shift  = pos_stream << pos_lz;
		pos_top    = pos_shift[44:20];
		pos_sum    = {1'b0, pos_top[24:1]} + {24'd0, pos_top[0]};
		pos_exp    = PosExpBase - {3'd0, pos_lz} + {7'd0, pos_sum[24]};
	end

	// x/32768 is exact: normalize the magnitude
	always_comb begin
		neg_m     = ~sample + 16'd1;
		neg_lz    = clz16(neg_m);
		neg_shift = neg_m << neg_lz;
		neg_exp   = NegExpBase - {3'd0, neg_lz};
	end

	// select sign branch
	always_comb begin
		if (sample[15]) begin
			float_bits = {1'b1, neg_exp, neg_shift[14:0], 8'd0};
		end else if (pos_s == 15'd0) begin
			float_bits = '0;
		end else begin
			float_bits = {1'b0, pos_exp, pos_sum[22:0]};
		end
	end

endmodule

/* src/int16_to_float_sample_converter_top.sv */
// Top level of the int16 to float sample converter.
// Depends on i2f_pkg and i2f_convert.
//
// Usage:
//   Drive sample and last with start high for one cycle per transfer; a
//   transfer is taken whenever start is high and busy is low. busy is
//   always low, so one sample can enter every cycle.
//   Each result appears on float_bits and last_out for exactly one cycle
//   with done high, after its transfer has passed the input register,
//   then the result register. Throughput is one sample per cycle, set
//   by the single conversion stage between the two registers.
//   Results leave in input order. The receiver cannot stall: it must take
//   each result in the cycle done is high.
//   Reset (arst_n low, asynchronous) clears the valid flags of both
//   stages, so no result is issued for samples in flight at reset.
//   There is no configuration and no state between samples.
module int16_to_float_sample_converter_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [i2f_pkg::SampleWidth-1:0] sample,
	input  logic                                   last,
	output logic                                   done,
	output logic        [i2f_pkg::FloatWidth-1:0]  float_bits,
	output logic                                   last_out
);
	import i2f_pkg::*;

	logic                          valid_s1;
	logic signed [SampleWidth-1:0] sample_s1;
	logic                          last_s1;
	logic [FloatWidth-1:0]         conv_bits;
	logic                          valid_s2;
	logic [FloatWidth-1:0]         bits_s2;
	logic                          last_s2;

	assign busy = 1'b0;

	// advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// capture the input transfer
	always_ff @(posedge clk) begin
		if (start) begin
			sample_s1 <= sample;
			last_s1   <= last;
		end
	end

	i2f_convert u_convert (
		.sample     (sample_s1),
		.float_bits (conv_bits)
	);

	// hold the result for its one output cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			bits_s2 <= conv_bits;
			last_s2 <= last_s1;
		end
	end

	assign done       = valid_s2;
	assign float_bits = bits_s2;
	assign last_out   = last_s2;

endmodule

/* dv/tb_top.sv */
// Testbench for the int16 to float sample converter.
// Checks every result against a built-in float scaling predictor.
// Depends on i2f_pkg and int16_to_float_sample_converter_top.
`timescale 1ns / 1ps

module tb_top;

	localparam real PosScale = 32767.0;
	localparam real NegScale = 32768.0;
	localparam int  StallLimit = 1000;

	typedef struct packed {
		logic [i2f_pkg::FloatWidth-1:0] bits;
		logic                           last;
	} scaled_sample_t;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   start;
	logic                                   busy;
	logic signed [i2f_pkg::SampleWidth-1:0] sample;
	logic                                   last;
	logic                                   done;
	logic        [i2f_pkg::FloatWidth-1:0]  float_bits;
	logic                                   last_out;

	scaled_sample_t pending_floats[$];
	int             error_count = 0;
	int             idle_cycles = 0;

	int16_to_float_sample_converter_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.last       (last),
		.done       (done),
		.float_bits (float_bits),
		.last_out   (last_out)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Scale to [-1, 1] in double, then round to nearest-even single.
	function automatic logic [31:0] scale_to_single(logic signed [15:0] s);
		real         q;
		logic [63:0] d;
		logic [31:0] r;
		logic [28:0] tail;
		if (s == 0) begin
			return 32'h0;
		end
		if (s > 0) begin
			q = $itor(s) / PosScale;
		end else begin
			q = $itor(s) / NegScale;
		end
		d = $realtobits(q);
		r = {d[63], 8'(d[62:52] - 11'd896), d[51:29]};
		tail = d[28:0];
		// carry out of the mantissa bumps the exponent, as intended
		if (tail > 29'h1000_0000 || (tail == 29'h1000_0000 && r[0])) begin
			r = r + 32'd1;
		end
		return r;
	endfunction

	// Drive one sample and hold it until the transfer happens.
	task automatic send_sample(input logic signed [15:0] s, input logic l);
		scaled_sample_t exp_item;
		start  <= 1'b1;
		sample <= s;
		last   <= l;
		forever begin
			@(negedge clk);
			if (!busy) begin
				break;
			end
			@(posedge clk);
		end
		@(posedge clk);
		exp_item.bits = scale_to_single(s);
		exp_item.last = l;
		pending_floats.push_back(exp_item);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		wait (pending_floats.size() == 0);
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				return 16'sh7FFF - 16'($urandom_range(0, 3));
			end
			1: begin
				return 16'sh8000 + 16'($urandom_range(0, 3));
			end
			2: begin
				return 16'($urandom_range(0, 8)) - 16'sd4;
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic test_extremes();
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd32767, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd32766, 1'b0);
		send_sample(-16'sd32767, 1'b1);
		send_sample(16'sh4000, 1'b0);
		send_sample(16'shC000, 1'b0);
		send_sample(16'sh5555, 1'b1);
		send_sample(16'shAAAA, 1'b0);
		send_sample(16'sd3, 1'b1);
		pause(2);
		send_sample(16'sd16384, 1'b0);
		send_sample(16'sh00FF, 1'b1);
		send_sample(16'shFF00, 1'b0);
		drain();
	endtask

	task automatic test_back_to_back();
		repeat (150) send_sample(random_sample(), 1'($urandom));
		drain();
	endtask

	task automatic test_bursts();
		int burst;
		for (int n = 0; n < 1000; n += burst) begin
			burst = $urandom_range(1, 20);
			repeat (burst) send_sample(random_sample(), ($urandom_range(0, 7) == 0));
			if ($urandom_range(0, 3) != 0) begin
				pause($urandom_range(1, 6));
			end
			if ($urandom_range(0, 30) == 0) begin
				drain();
			end
		end
		drain();
	endtask

	// Compare each result with the oldest expectation.
	always @(negedge clk) begin
		scaled_sample_t exp_item;
		if (arst_n && done) begin
			if (pending_floats.size() == 0) begin
				$error("result with no expectation: float_bits %h", float_bits);
				error_count++;
			end else begin
				exp_item = pending_floats.pop_front();
				if (float_bits !== exp_item.bits) begin
					$error("float_bits expected %h actual %h", exp_item.bits, float_bits);
					error_count++;
				end
				if (last_out !== exp_item.last) begin
					$error("last_out expected %b actual %b", exp_item.last, last_out);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when neither a transfer nor a result happens for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		sample = '0;
		last   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_back_to_back();
		test_bursts();
		repeat (6) @(posedge clk);
		if (error_count == 0 && pending_floats.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
src/i2f_pkg.sv
src/i2f_convert.sv
src/int16_to_float_sample_converter_top.sv
dv/tb_top.sv
